FILE: hdl/cgts_pkg.sv
// Shared types and constants for the levelled topological sort block.
package cgts_pkg;

	// Field widths of requests and results.
	localparam int ACTION_W  = 2;
	localparam int NODE_W    = 5;
	localparam int LEVEL_W   = 5;
	localparam int UNVIS_W   = 6;
	localparam int LEVEL_MAX = 31;

	// Request action codes.
	localparam logic [ACTION_W-1:0] ACT_NODE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SORT = 2'd2;

	// Result kinds.
	localparam logic KIND_NODE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_FETCH,
		ST_EMIT,
		ST_SWEEP,
		ST_SUMMARY
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic sort_init;
		logic seed_step;
		logic q_rd;
		logic emit_node;
		logic sweep;
		logic summary;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seed_last;
		logic q_empty;
		logic sweep_done;
	} sts_t;

endpackage

FILE: hdl/cgts_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
module cgts_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/cgts_ctrl.sv
// Sequencer for loading, seeding, queue walking, edge sweeps and the summary.
module cgts_ctrl import cgts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ACTION_W-1:0] action,
	input  sts_t                sts,
	output cmd_t                cmd,
	output logic                busy
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (action == ACT_SORT) begin
						cmd.sort_init = 1'b1;
						state_d       = ST_SEED;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SEED: begin
				cmd.seed_step = 1'b1;
				if (sts.seed_last) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (sts.q_empty) begin
					state_d = ST_SUMMARY;
				end else begin
					cmd.q_rd = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_node = 1'b1;
				state_d       = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_d = ST_FETCH;
				end
			end
			ST_SUMMARY: begin
				cmd.summary = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The block only returns to idle after issuing the summary.
	a_idle_after_summary: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(state_q == ST_SUMMARY))
		else $error("busy fell outside the summary state");

endmodule

FILE: hdl/cgts_dp.sv
// Graph storage, order queue, counters and result registers.
module cgts_dp import cgts_pkg::*; #(
	parameter int MAX_NODES = 32,
	parameter int MAX_EDGES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [ACTION_W-1:0] action,
	input  logic [NODE_W-1:0]   caller_node,
	input  logic [NODE_W-1:0]   callee_node,
	output sts_t                sts,
	output logic                strobe,
	output logic                kind,
	output logic [NODE_W-1:0]   node_id,
	output logic [LEVEL_W-1:0]  level,
	output logic [UNVIS_W-1:0]  unvisited_count,
	output logic                edge_overflow,
	output logic                last
);

	localparam int NODE_SLOTS = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
	localparam int NW   = $clog2(NODE_SLOTS);
	localparam int QW   = $clog2(NODE_SLOTS + 1);
	localparam int EW   = $clog2(MAX_EDGES);
	localparam int ECW  = $clog2(MAX_EDGES + 1);
	localparam int QD_W = NODE_W + LEVEL_W;
	localparam int ED_W = 2 * NODE_W;

	// Per-node state.
	logic [NODE_SLOTS-1:0] present_q;
	logic [NODE_SLOTS-1:0] visited_q;
	logic [ECW-1:0]        pend_q [NODE_SLOTS];

	// Counters.
	logic [ECW-1:0] edge_cnt_q;
	logic           ovf_q;
	logic [NW-1:0]  sidx_q;
	logic [QW-1:0]  qlen_q;
	logic [QW-1:0]  qfront_q;
	logic [QW-1:0]  present_cnt_q;
	logic [ECW-1:0] eidx_q;
	logic           evalid_s1;

	// Node being dequeued.
	logic [NODE_W-1:0]  f_q;
	logic [LEVEL_W-1:0] lv_q;

	// Result registers.
	logic                strobe_q;
	logic                kind_q;
	logic [NODE_W-1:0]   node_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [UNVIS_W-1:0]  unvis_q;
	logic                ovf_out_q;
	logic                last_q;

	logic [NW-1:0]      ia;
	logic [NW-1:0]      ib;
	logic               a_ok;
	logic               b_ok;
	logic               node_ld;
	logic               edge_ld;
	logic               edge_room;
	logic               edge_st;
	logic               edge_drop;
	logic               seed_hit;
	logic               e_issue;
	logic [ED_W-1:0]    e_rdata;
	logic [NODE_W-1:0]  ec_caller;
	logic [NODE_W-1:0]  ec_callee;
	logic [NW-1:0]      ci;
	logic               hit;
	logic               hit_enq;
	logic [LEVEL_W-1:0] nxt_lv;
	logic               q_we;
	logic [QD_W-1:0]    q_wdata;
	logic [QD_W-1:0]    q_rdata;

	// Load decode: ids beyond the node table drop the whole request.
	assign ia        = caller_node[NW-1:0];
	assign ib        = callee_node[NW-1:0];
	assign a_ok      = int'(caller_node) < NODE_SLOTS;
	assign b_ok      = int'(callee_node) < NODE_SLOTS;
	assign node_ld   = cmd.load && (action == ACT_NODE) && a_ok;
	assign edge_ld   = cmd.load && (action == ACT_EDGE) && a_ok && b_ok;
	assign edge_room = edge_cnt_q < ECW'(MAX_EDGES);
	assign edge_st   = edge_ld && (caller_node != callee_node) && edge_room;
	assign edge_drop = edge_ld && (caller_node != callee_node) && !edge_room;

	// Seeding scans node ids in ascending order for leaves.
	assign seed_hit = cmd.seed_step && present_q[sidx_q] && (pend_q[sidx_q] == '0)
		&& (int'(qlen_q) < NODE_SLOTS);

	// Edge sweep: a read is issued each cycle and evaluated in the cycle after.
	assign e_issue   = cmd.sweep && (eidx_q < edge_cnt_q);
	assign ec_caller = e_rdata[ED_W-1:NODE_W];
	assign ec_callee = e_rdata[NODE_W-1:0];
	assign ci        = ec_caller[NW-1:0];
	assign hit       = evalid_s1 && (ec_callee == f_q) && (pend_q[ci] != '0) && !visited_q[ci];
	assign hit_enq   = hit && (pend_q[ci] == ECW'(1)) && (int'(qlen_q) < NODE_SLOTS);
	assign nxt_lv    = (lv_q == LEVEL_W'(LEVEL_MAX)) ? lv_q : lv_q + 1'b1;

	// Queue write mux.
	assign q_we    = seed_hit || hit_enq;
	assign q_wdata = seed_hit ? {NODE_W'(sidx_q), LEVEL_W'(0)} : {ec_caller, nxt_lv};

	// Status to the controller.
	assign sts.seed_last  = sidx_q == NW'(NODE_SLOTS - 1);
	assign sts.q_empty    = qfront_q == qlen_q;
	assign sts.sweep_done = !(eidx_q < edge_cnt_q) && !evalid_s1;

	// Edge store, caller in the upper half.
	cgts_ram #(
		.WIDTH(ED_W),
		.DEPTH(MAX_EDGES)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_st),
		.waddr (edge_cnt_q[EW-1:0]),
		.wdata ({caller_node, callee_node}),
		.raddr (eidx_q[EW-1:0]),
		.rdata (e_rdata)
	);

	// Order queue of node and level.
	cgts_ram #(
		.WIDTH(QD_W),
		.DEPTH(NODE_SLOTS)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (qlen_q[NW-1:0]),
		.wdata (q_wdata),
		.raddr (qfront_q[NW-1:0]),
		.rdata (q_rdata)
	);

	// Pending callee counts per node.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_SLOTS; i++) begin
				pend_q[i] <= '0;
			end
		end else if (cmd.summary) begin
			for (int i = 0; i < NODE_SLOTS; i++) begin
				pend_q[i] <= '0;
			end
		end else if (edge_st) begin
			pend_q[ia] <= pend_q[ia] + 1'b1;
		end else if (hit) begin
			pend_q[ci] <= pend_q[ci] - 1'b1;
		end
	end

	// Presence and visited flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			visited_q <= '0;
		end else if (cmd.summary) begin
			present_q <= '0;
			visited_q <= '0;
		end else begin
			if (node_ld || edge_ld) begin
				present_q[ia] <= 1'b1;
			end
			if (edge_ld) begin
				present_q[ib] <= 1'b1;
			end
			if (seed_hit) begin
				visited_q[sidx_q] <= 1'b1;
			end else if (hit_enq) begin
				visited_q[ci] <= 1'b1;
			end
		end
	end

	// Edge count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.summary) begin
			edge_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else begin
			if (edge_st) begin
				edge_cnt_q <= edge_cnt_q + 1'b1;
			end
			if (edge_drop) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Seed scan, queue pointers and present count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q        <= '0;
			qlen_q        <= '0;
			qfront_q      <= '0;
			present_cnt_q <= '0;
		end else if (cmd.sort_init) begin
			sidx_q        <= '0;
			qlen_q        <= '0;
			qfront_q      <= '0;
			present_cnt_q <= '0;
		end else begin
			if (cmd.seed_step) begin
				sidx_q <= sidx_q + 1'b1;
				if (present_q[sidx_q]) begin
					present_cnt_q <= present_cnt_q + 1'b1;
				end
			end
			if (q_we) begin
				qlen_q <= qlen_q + 1'b1;
			end
			if (cmd.q_rd) begin
				qfront_q <= qfront_q + 1'b1;
			end
		end
	end

	// Edge sweep address and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eidx_q    <= '0;
			evalid_s1 <= 1'b0;
		end else begin
			evalid_s1 <= e_issue;
			if (cmd.emit_node) begin
				eidx_q <= '0;
			end else if (e_issue) begin
				eidx_q <= eidx_q + 1'b1;
			end
		end
	end

	// Capture the dequeued node.
	always_ff @(posedge clk) begin
		if (cmd.emit_node) begin
			f_q  <= q_rdata[QD_W-1:LEVEL_W];
			lv_q <= q_rdata[LEVEL_W-1:0];
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_node || cmd.summary;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_node) begin
			kind_q    <= KIND_NODE;
			node_q    <= q_rdata[QD_W-1:LEVEL_W];
			level_q   <= q_rdata[LEVEL_W-1:0];
			unvis_q   <= '0;
			ovf_out_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (cmd.summary) begin
			kind_q    <= KIND_SUMMARY;
			node_q    <= '0;
			level_q   <= '0;
			unvis_q   <= UNVIS_W'(QW'(present_cnt_q - qlen_q));
			ovf_out_q <= ovf_q;
			last_q    <= 1'b1;
		end
	end

	assign strobe          = strobe_q;
	assign kind            = kind_q;
	assign node_id         = node_q;
	assign level           = level_q;
	assign unvisited_count = unvis_q;
	assign edge_overflow   = ovf_out_q;
	assign last            = last_q;

	// The queue read pointer never overtakes the write pointer.
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		qfront_q <= qlen_q)
		else $error("order queue read pointer passed write pointer");

	// The edge count stays within the store.
	a_edge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(edge_cnt_q) <= MAX_EDGES)
		else $error("edge count beyond capacity");

	// Evaluated edge data always follows an advanced sweep address.
	a_sweep_addr: assert property (@(posedge clk) disable iff (!arst_n)
		evalid_s1 |-> (eidx_q != '0))
		else $error("edge data valid without an issued read");

	// Only present nodes can have been queued by summary time.
	a_summary_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.summary |-> (qlen_q <= present_cnt_q))
		else $error("more nodes queued than present");

endmodule

FILE: hdl/call_graph_level_topo_sort.sv
// Channel   | Handshake         | Payload
// ----------+-------------------+-------------------------------------------------
// request   | start && !busy    | action, caller_node, callee_node
// result    | strobe (1 cycle)  | kind, node_id, level, unvisited_count,
//           |                   | edge_overflow, last
//
// Node and edge requests leave busy low, so one may follow every cycle.
// A sort request runs a seed scan over the node table, then for each queued node one
// queue fetch, one emit and a sweep of all stored edges through the edge RAM's
// single read port, then the summary.
// Reset is asynchronous and clears the graph at once; the edge store needs no clearing.
// Results cannot be stalled: each is shown for exactly one cycle with strobe high.
module call_graph_level_topo_sort import cgts_pkg::*; #(
	parameter int MAX_NODES = 32,
	parameter int MAX_EDGES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ACTION_W-1:0] action,
	input  logic [NODE_W-1:0]   caller_node,
	input  logic [NODE_W-1:0]   callee_node,
	output logic                strobe,
	output logic                kind,
	output logic [NODE_W-1:0]   node_id,
	output logic [LEVEL_W-1:0]  level,
	output logic [UNVIS_W-1:0]  unvisited_count,
	output logic                edge_overflow,
	output logic                last
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	cgts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Storage and result datapath.
	cgts_dp #(
		.MAX_NODES(MAX_NODES),
		.MAX_EDGES(MAX_EDGES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (action),
		.caller_node     (caller_node),
		.callee_node     (callee_node),
		.sts             (sts),
		.strobe          (strobe),
		.kind            (kind),
		.node_id         (node_id),
		.level           (level),
		.unvisited_count (unvisited_count),
		.edge_overflow   (edge_overflow),
		.last            (last)
	);

endmodule

FILE: tb/topo_sort_checker.sv
// Watches the request and result channels of the levelled topological sort block,
// keeps its own copy of the graph and compares every result with the one predicted.
module topo_sort_checker import cgts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [ACTION_W-1:0] action,
	input  logic [NODE_W-1:0]   caller_node,
	input  logic [NODE_W-1:0]   callee_node,
	input  logic                strobe,
	input  logic                kind,
	input  logic [NODE_W-1:0]   node_id,
	input  logic [LEVEL_W-1:0]  level,
	input  logic [UNVIS_W-1:0]  unvisited_count,
	input  logic                edge_overflow,
	input  logic                last,
	output int                  mismatch_count,
	output int                  entries_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 32;
	localparam int EDGES = 256;

	// One emitted entry of a sort run.
	typedef struct {
		logic                kind;
		logic [NODE_W-1:0]   node;
		logic [LEVEL_W-1:0]  level;
		logic [UNVIS_W-1:0]  unvisited;
		logic                overflow;
		logic                last;
	} sort_entry_t;

	// Predicted entries still to be seen on the result channel, oldest first.
	sort_entry_t sort_entries_due[$];
	sort_entry_t seen_entry;

	// Graph as loaded since the last sort.
	bit                present[NODES];
	int unsigned       callees_left[NODES];
	bit                reached[NODES];
	logic [NODE_W-1:0] edge_from[EDGES];
	logic [NODE_W-1:0] edge_to[EDGES];
	int unsigned       n_edges;
	bit                dropped_edge;

	function automatic void clear_graph_copy();
		for (int i = 0; i < NODES; i++) begin
			present[i]      = 1'b0;
			callees_left[i] = 0;
			reached[i]      = 1'b0;
		end
		n_edges      = 0;
		dropped_edge = 1'b0;
	endfunction

	// Kahn's algorithm with levels: leaves seeded in ascending id, callers visited
	// in the order their edges were loaded, then one summary entry.
	function automatic void predict_sort_run();
		logic [NODE_W-1:0]  q_node[NODES];
		logic [LEVEL_W-1:0] q_level[NODES];
		int                 qlen;
		int                 qhead;
		int                 n_present;
		logic [NODE_W-1:0]  front;
		int                 lv;
		logic [NODE_W-1:0]  caller;
		sort_entry_t        ent;

		qlen      = 0;
		qhead     = 0;
		n_present = 0;
		for (int i = 0; i < NODES; i++) begin
			if (present[i]) begin
				n_present++;
				if (callees_left[i] == 0 && qlen < NODES) begin
					q_node[qlen]  = NODE_W'(i);
					q_level[qlen] = '0;
					qlen++;
					reached[i] = 1'b1;
				end
			end
		end
		while (qhead < qlen) begin
			front = q_node[qhead];
			lv    = q_level[qhead];
			qhead++;
			for (int e = 0; e < n_edges; e++) begin
				if (edge_to[e] == front) begin
					caller = edge_from[e];
					// A caller with nothing left to wait on, or already queued, is skipped.
					if (callees_left[caller] != 0 && !reached[caller]) begin
						callees_left[caller]--;
						if (callees_left[caller] == 0 && qlen < NODES) begin
							q_node[qlen]  = caller;
							q_level[qlen] = (lv >= LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(lv + 1);
							qlen++;
							reached[caller] = 1'b1;
						end
					end
				end
			end
		end
		for (int i = 0; i < qlen; i++) begin
			ent = '{KIND_NODE, q_node[i], q_level[i], '0, 1'b0, 1'b0};
			sort_entries_due.insert(sort_entries_due.size(), ent);
		end
		ent = '{KIND_SUMMARY, '0, '0, UNVIS_W'(n_present - qlen), dropped_edge, 1'b1};
		sort_entries_due.insert(sort_entries_due.size(), ent);
		clear_graph_copy();
	endfunction

	// Applies one accepted request to the graph copy.
	function automatic void apply_request(logic [ACTION_W-1:0] act, logic [NODE_W-1:0] from_id,
			logic [NODE_W-1:0] to_id);
		case (act)
			ACT_NODE: begin
				present[from_id] = 1'b1;
			end
			ACT_EDGE: begin
				present[from_id] = 1'b1;
				present[to_id]   = 1'b1;
				// Self edges only declare the node; a full store drops the edge.
				if (from_id != to_id) begin
					if (n_edges >= EDGES) begin
						dropped_edge = 1'b1;
					end else begin
						edge_from[n_edges] = from_id;
						edge_to[n_edges]   = to_id;
						n_edges++;
						callees_left[from_id]++;
					end
				end
			end
			ACT_SORT: begin
				predict_sort_run();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void compare_field(string fname, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", fname, want, got);
			mismatch_count++;
		end
	endfunction

	// Results are checked before the request of the same edge is applied, so that
	// a sort accepted together with a result never jumps the queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_graph_copy();
			sort_entries_due.delete();
		end else begin
			if (strobe === 1'b1) begin
				if (sort_entries_due.size() == 0) begin
					$error("result with no entry expected: kind %0d, node_id %0d", kind, node_id);
					mismatch_count++;
				end else begin
					seen_entry = sort_entries_due.pop_front();
					compare_field("kind", 8'(seen_entry.kind), 8'(kind));
					compare_field("node_id", 8'(seen_entry.node), 8'(node_id));
					compare_field("level", 8'(seen_entry.level), 8'(level));
					compare_field("unvisited_count", 8'(seen_entry.unvisited),
						8'(unvisited_count));
					compare_field("edge_overflow", 8'(seen_entry.overflow), 8'(edge_overflow));
					compare_field("last", 8'(seen_entry.last), 8'(last));
				end
			end
			if (start && !busy)
				apply_request(action, caller_node, callee_node);
		end
		entries_due <= sort_entries_due.size();
	end

endmodule

FILE: tb/call_graph_level_topo_sort_test.sv
// Drives graphs of nodes and call edges into the sort block and gives the verdict.
module call_graph_level_topo_sort_test import cgts_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Action code that the block ignores.
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
	// Cycles without any request or result before the run is abandoned.
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 64;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                start       = 1'b0;
	logic [ACTION_W-1:0] action      = ACT_NODE;
	logic [NODE_W-1:0]   caller_node = '0;
	logic [NODE_W-1:0]   callee_node = '0;
	logic                busy;
	logic                strobe;
	logic                kind;
	logic [NODE_W-1:0]   node_id;
	logic [LEVEL_W-1:0]  level;
	logic [UNVIS_W-1:0]  unvisited_count;
	logic                edge_overflow;
	logic                last;
	int                  fail_total;
	int                  results_due;

	int idle_pct;
	int requests_sent;
	int quiet_cycles;

	call_graph_level_topo_sort u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .caller_node(caller_node), .callee_node(callee_node),
		.strobe(strobe), .kind(kind), .node_id(node_id), .level(level),
		.unvisited_count(unvisited_count), .edge_overflow(edge_overflow), .last(last)
	);

	topo_sort_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .caller_node(caller_node), .callee_node(callee_node),
		.strobe(strobe), .kind(kind), .node_id(node_id), .level(level),
		.unvisited_count(unvisited_count), .edge_overflow(edge_overflow), .last(last),
		.mismatch_count(fail_total), .entries_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: any accepted request or result restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Presents one request and holds it until accepted, then idles at random.
	task automatic push_request(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] from_id,
			input logic [NODE_W-1:0] to_id);
		start       <= 1'b1;
		action      <= act;
		caller_node <= from_id;
		callee_node <= to_id;
		do @(posedge clk); while (busy);
		requests_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start       <= 1'b0;
			action      <= ACT_SORT;
			caller_node <= NODE_W'($urandom);
			callee_node <= NODE_W'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Random ordering of all node ids, used to rank nodes so that edges form a DAG.
	task automatic shuffle_ids(output logic [NODE_W-1:0] ids[32]);
		int j;
		logic [NODE_W-1:0] tmp;

		for (int i = 0; i < 32; i++)
			ids[i] = NODE_W'(i);
		for (int i = 31; i > 0; i--) begin
			j       = $urandom_range(i);
			tmp     = ids[i];
			ids[i]  = ids[j];
			ids[j]  = tmp;
		end
	endtask

	// Mostly acyclic graph on a few nodes, with self, duplicate and back edges mixed in.
	task automatic load_dag();
		logic [NODE_W-1:0] ids[32];
		logic [NODE_W-1:0] prev_from;
		logic [NODE_W-1:0] prev_to;
		int n_nodes;
		int n_items;
		int hi;
		int lo;
		int pick;

		shuffle_ids(ids);
		n_nodes   = ($urandom_range(9) == 0) ? $urandom_range(13, 32) : $urandom_range(2, 12);
		n_items   = $urandom_range(n_nodes, 2 * n_nodes + 4);
		prev_from = ids[1];
		prev_to   = ids[0];
		for (int k = 0; k < n_items; k++) begin
			hi   = $urandom_range(1, n_nodes - 1);
			lo   = $urandom_range(0, hi - 1);
			pick = $urandom_range(99);
			if (pick < 8) begin
				push_request(ACT_EDGE, ids[lo], ids[lo]);
			end else if (pick < 14) begin
				push_request(ACT_EDGE, ids[lo], ids[hi]);
			end else if (pick < 20) begin
				push_request(ACT_NODE, ids[$urandom_range(n_nodes - 1)], NODE_W'($urandom));
			end else if (pick < 23) begin
				push_request(ACT_NONE, NODE_W'($urandom), NODE_W'($urandom));
			end else if (pick < 30) begin
				push_request(ACT_EDGE, prev_from, prev_to);
			end else begin
				prev_from = ids[hi];
				prev_to   = ids[lo];
				push_request(ACT_EDGE, prev_from, prev_to);
			end
		end
		push_request(ACT_SORT, NODE_W'($urandom), NODE_W'($urandom));
	endtask

	// Unstructured requests of every action, closed by a sort.
	task automatic load_noise();
		int n_items;

		n_items = $urandom_range(3, 12);
		for (int k = 0; k < n_items; k++)
			push_request(ACTION_W'($urandom_range(3)), NODE_W'($urandom), NODE_W'($urandom));
		push_request(ACT_SORT, NODE_W'($urandom), NODE_W'($urandom));
	endtask

	// One chain through all nodes, which reaches the deepest level.
	task automatic load_chain();
		logic [NODE_W-1:0] ids[32];

		shuffle_ids(ids);
		for (int k = 0; k < 31; k++)
			push_request(ACT_EDGE, ids[k + 1], ids[k]);
		push_request(ACT_SORT, '0, '0);
	endtask

	initial begin
		int pct[3];
		int target;

		pct           = '{20, 54, 0};
		idle_pct      = 0;
		requests_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty sort, duplicate, self and ignored requests, a cycle.
		push_request(ACT_SORT, '0, '0);
		push_request(ACT_NODE, 5'd31, 5'd0);
		push_request(ACT_NODE, 5'd0, 5'd31);
		push_request(ACT_NONE, 5'd7, 5'd9);
		push_request(ACT_EDGE, 5'd1, 5'd0);
		push_request(ACT_EDGE, 5'd1, 5'd0);
		push_request(ACT_EDGE, 5'd2, 5'd1);
		push_request(ACT_EDGE, 5'd31, 5'd2);
		push_request(ACT_EDGE, 5'd3, 5'd3);
		push_request(ACT_EDGE, 5'd10, 5'd11);
		push_request(ACT_EDGE, 5'd11, 5'd10);
		push_request(ACT_EDGE, 5'd12, 5'd10);
		push_request(ACT_NODE, 5'd21, 5'd21);
		push_request(ACT_SORT, 5'd31, 5'd31);
		// Edges into the highest id, then a graph holding only a self edge.
		push_request(ACT_EDGE, 5'd0, 5'd31);
		push_request(ACT_EDGE, 5'd21, 5'd31);
		push_request(ACT_EDGE, 5'd21, 5'd0);
		push_request(ACT_SORT, '0, '0);
		push_request(ACT_EDGE, 5'd5, 5'd5);
		push_request(ACT_SORT, '0, '0);

		// Random part in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = pct[ph];
			if (ph == 0)
				load_chain();
			target = requests_sent + 30;
			while (requests_sent < target) begin
				if ($urandom_range(99) < 75)
					load_dag();
				else
					load_noise();
			end
		end
		start <= 1'b0;

		// Drain the outstanding results, then watch for strays.
		do @(negedge clk); while (results_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_total == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
